/* rtl/fpdf_pkg.sv */
`timescale 1ns / 1ps

package fpdf_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int VALUE_W     = 32;
    localparam int NUM_BCD     = 10;                       // decimal digits of a 32-bit value
    localparam int DIG_IDX_W   = $clog2(NUM_BCD);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int CFG_W       = 5;
    localparam int SUM_W       = CFG_W + 1;
    localparam int CHAR_W      = 7;
    localparam int IDX_W       = 2;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);

    localparam logic [IDX_W-1:0] REG_INT_DIGITS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAC_DIGITS = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIGNED_MODE = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    typedef logic [NUM_BCD-1:0][3:0] bcd_vec_t;

    typedef struct packed {
        logic [CFG_W-1:0] int_digits;
        logic [CFG_W-1:0] frac_digits;
        logic             signed_mode;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] mag;
    } conv_req_t;

    typedef struct packed {
        logic     done;
        bcd_vec_t digits;
    } conv_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT,
        ST_POINT
    } state_t;

endpackage

/* rtl/fpdf_dabble.sv */
`timescale 1ns / 1ps

// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module fpdf_dabble
    import fpdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  conv_req_t req,
    output conv_rsp_t rsp
);

    logic [VALUE_W-1:0]     bin_reg, bin_next;
    bcd_vec_t               bcd_reg, bcd_next;
    logic [SHIFT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    bcd_vec_t               adj;
    logic [4*NUM_BCD-1:0]   adj_bits;

    always_comb begin
        for (int k = 0; k < NUM_BCD; k++) begin
            adj[k] = (bcd_reg[k] >= 4'd5) ? (bcd_reg[k] + 4'd3) : bcd_reg[k];
        end
    end

    assign adj_bits = adj;

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            bin_next  = req.mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj_bits[4*NUM_BCD-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SHIFT_CNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.digits = bcd_reg;

endmodule

/* rtl/fpdf_ctrl.sv */
`timescale 1ns / 1ps

// Sequencer: starts the converter, sizes the field, then emits characters.
module fpdf_ctrl
    import fpdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output conv_req_t          req,
    input  conv_rsp_t          rsp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_out_char,
    output logic               m_last_char
);

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    point_reg, point_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;

    logic                accept;
    logic                fire;
    logic                neg_in;
    logic [3:0]          ndig;
    logic [SUM_W-1:0]    want;
    logic [SUM_W-1:0]    total_w;
    logic [SUM_W-1:0]    frac_w;
    logic [CNT_W-1:0]    dig_pos;
    logic [3:0]          dig_val;
    logic                pos_is_end;
    logic                pos_at_point;

    assign accept = s_valid && s_ready;
    assign fire   = !m_valid_reg || m_ready;
    assign neg_in = cfg.signed_mode && s_value[VALUE_W-1];

    // Significant digit count, at least one.
    always_comb begin
        ndig = 4'd1;
        for (int k = 1; k < NUM_BCD; k++) begin
            if (rsp.digits[k] != 4'd0) begin
                ndig = 4'(k + 1);
            end
        end
    end

    always_comb begin
        want = SUM_W'(cfg.int_digits) + SUM_W'(cfg.frac_digits);
        if (want > SUM_W'(MAX_DIGITS)) begin
            want = SUM_W'(MAX_DIGITS);
        end
        total_w = (SUM_W'(ndig) > want) ? SUM_W'(ndig) : want;
        frac_w  = SUM_W'(cfg.frac_digits);
    end

    // Positions above the significant digits hold zero in the BCD word.
    assign dig_pos = total_reg - CNT_W'(1) - pos_reg;
    always_comb begin
        if (dig_pos < CNT_W'(NUM_BCD)) begin
            dig_val = rsp.digits[dig_pos[DIG_IDX_W-1:0]];
        end else begin
            dig_val = 4'd0;
        end
    end

    assign pos_is_end   = (pos_reg == total_reg - CNT_W'(1));
    assign pos_at_point = (point_reg != '0) && (pos_reg + CNT_W'(1) == point_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (rsp.done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (fire) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (fire) begin
                    if (pos_at_point) begin
                        state_next = ST_POINT;
                    end else if (pos_is_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_POINT: begin
                if (fire) begin
                    state_next = (pos_reg == total_reg) ? ST_IDLE : ST_DIGIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready      = 1'b0;
        req.start    = 1'b0;
        req.mag      = neg_in ? (~s_value + 1'b1) : s_value;
        neg_next     = neg_reg;
        total_next   = total_reg;
        point_next   = point_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    req.start = 1'b1;
                    neg_next  = neg_in;
                end
            end
            ST_CONV: begin
            end
            ST_SCAN: begin
                total_next = CNT_W'(total_w);
                point_next = (total_w > frac_w) ? CNT_W'(total_w - frac_w) : '0;
                pos_next   = '0;
            end
            ST_SIGN: begin
                if (fire) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                end
            end
            ST_DIGIT: begin
                if (fire) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO + CHAR_W'(dig_val);
                    // a trailing point takes the last flag when it follows the last digit
                    m_last_next  = pos_is_end && (point_reg != total_reg);
                    pos_next     = pos_reg + CNT_W'(1);
                end
            end
            ST_POINT: begin
                if (fire) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_POINT;
                    m_last_next  = (pos_reg == total_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        total_reg  <= total_next;
        point_reg  <= point_next;
        pos_reg    <= pos_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

/* rtl/fixed_point_decimal_formatter.sv */
`timescale 1ns / 1ps

// Fixed-point decimal formatter.
// Input channel (s_valid/s_ready/s_value): one 32-bit number per transaction.
// Output channel (m_valid/m_ready/m_out_char/m_last_char): one ASCII character
// per transaction, '-' first for a negative number in signed mode, then the
// zero-padded digits with a '.' placed frac_digits from the end, none when
// frac_digits reaches the digit count; m_last_char marks the number's final character.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write int_digits (0),
// frac_digits (1) and signed_mode (2); other indexes are ignored. Write only
// while the block is idle.
// Flow: the shift-and-add-3 converter takes one input bit per cycle, then the
// sequencer picks up its done flag and sizes the field; the first character
// then enters the output register, followed by one character per cycle while
// the receiver does not stall, 1 to 18 of them. The next number is taken once
// its last character sits in the output register.
// A stalled receiver holds the current character; the sequencer waits.
// Reset (aresetn, synchronous, active low) empties the pipeline and restores
// int_digits = 1, frac_digits = 0, signed_mode = 0.
module fixed_point_decimal_formatter
    import fpdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_out_char,
    output logic               m_last_char
);

    cfg_t      cfg_reg, cfg_next;
    conv_req_t req;
    conv_rsp_t rsp;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_INT_DIGITS:  cfg_next.int_digits  = cfg_wdata;
                REG_FRAC_DIGITS: cfg_next.frac_digits = cfg_wdata;
                REG_SIGNED_MODE: cfg_next.signed_mode = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.int_digits  <= CFG_W'(1);
            cfg_reg.frac_digits <= '0;
            cfg_reg.signed_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fpdf_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    fpdf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .req         (req),
        .rsp         (rsp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule

/* rtl/fpdf_checker.sv */
`timescale 1ns / 1ps

module fpdf_checker
    import fpdf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAR_W-1:0] m_out_char,
    input logic              m_last_char
);

    // stalled output holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last_char))
        else $error("output changed while stalled");

    // the input is still closed during the converter's last shift
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##31 !s_ready)
        else $error("input reopened during conversion");

    // only the final character may wait while a new number can be taken
    a_ready_only_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && s_ready |-> m_last_char)
        else $error("input ready with a non-final character pending");

    // a sign never ends a number
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_char == CHAR_MINUS) |-> !m_last_char)
        else $error("sign flagged as last character");

endmodule

bind fixed_point_decimal_formatter fpdf_checker u_fpdf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_char  (m_out_char),
    .m_last_char (m_last_char)
);
